/* hdl/etas_pkg.sv */
// ----------------------------------------------------------------------------
// etas_pkg
// Shared codes and types of the expiry table aging sweep.
// ----------------------------------------------------------------------------
package etas_pkg;

   localparam int GRACE_W = 32;
   localparam logic [GRACE_W-1:0] GRACE_RESET = 32'd10;

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_SWEEP  = 2'd2;

   localparam logic [1:0] KIND_EXPIRED = 2'd0;
   localparam logic [1:0] KIND_FREED   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   typedef struct packed {
      logic used;
      logic expired;
   } slot_flags_type;

   typedef struct packed {
      logic       emit;
      logic [1:0] kind;
      logic       clr_used;
      logic       set_expired;
      logic       keep;
      logic       take_min;
   } age_ctl_type;

endpackage

/* hdl/etas_req_if.sv */
// ----------------------------------------------------------------------------
// etas_req_if
// Request channel: table write, remove or sweep.
// ----------------------------------------------------------------------------
interface etas_req_if #(
   parameter int TIME_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [4:0]           slot;
   logic [TIME_BITS-1:0] expiry_time;
   logic [TIME_BITS-1:0] now_time;

   modport source (output valid, output mode, output slot, output expiry_time,
                   output now_time, input ready);
   modport sink   (input valid, input mode, input slot, input expiry_time,
                   input now_time, output ready);
endinterface

/* hdl/etas_rsp_if.sv */
// ----------------------------------------------------------------------------
// etas_rsp_if
// Result channel: expiry and free events, sweep summary.
// ----------------------------------------------------------------------------
interface etas_rsp_if #(
   parameter int TIME_BITS = 32
);
   logic               valid;
   logic               ready;
   logic [1:0]         event_kind;
   logic [4:0]         event_slot;
   logic [TIME_BITS:0] next_deadline;
   logic               deadline_valid;
   logic               last;

   modport source (output valid, output event_kind, output event_slot,
                   output next_deadline, output deadline_valid, output last,
                   input ready);
   modport sink   (input valid, input event_kind, input event_slot,
                   input next_deadline, input deadline_valid, input last,
                   output ready);
endinterface

/* hdl/etas_csr_if.sv */
// ----------------------------------------------------------------------------
// etas_csr_if
// Configuration write channel for the grace period register.
// ----------------------------------------------------------------------------
interface etas_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

/* hdl/etas_slot_table.sv */
// ----------------------------------------------------------------------------
// etas_slot_table
// Slot flags in flip-flops and deadline memory with a registered read port.
// ----------------------------------------------------------------------------
module etas_slot_table #(
   parameter int TABLE_DEPTH = 32,
   parameter int TIME_BITS   = 32,
   parameter int IDX_W       = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  logic [TIME_BITS-1:0]    wr_data,
   input  logic                    rd_en,
   input  logic [IDX_W-1:0]        rd_idx,
   output logic [TIME_BITS-1:0]    rd_data,
   input  logic                    upd_en,
   input  logic [IDX_W-1:0]        upd_idx,
   input  etas_pkg::slot_flags_type upd_flags,
   input  logic [IDX_W-1:0]        flag_idx,
   output etas_pkg::slot_flags_type flags
);

   logic [TIME_BITS-1:0]   deadline_mem [TABLE_DEPTH];
   logic [TIME_BITS-1:0]   rd_data_ff;
   logic [TABLE_DEPTH-1:0] used_ff;
   logic [TABLE_DEPTH-1:0] expired_ff;

   // deadline contents only matter while the used bit is set
   always_ff @(posedge clock) begin
      if (wr_en) begin
         deadline_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= deadline_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         expired_ff <= '0;
      end else if (upd_en) begin
         used_ff[upd_idx]    <= upd_flags.used;
         expired_ff[upd_idx] <= upd_flags.expired;
      end
   end

   assign rd_data       = rd_data_ff;
   assign flags.used    = used_ff[flag_idx];
   assign flags.expired = expired_ff[flag_idx];

endmodule

/* hdl/etas_age_unit.sv */
// ----------------------------------------------------------------------------
// etas_age_unit
// Shared add and compare unit that judges one slot per sweep step.
// ----------------------------------------------------------------------------
module etas_age_unit #(
   parameter int TIME_BITS = 32
) (
   input  etas_pkg::slot_flags_type       flags,
   input  logic [TIME_BITS-1:0]           deadline,
   input  logic [TIME_BITS-1:0]           now,
   input  logic [etas_pkg::GRACE_W-1:0]   grace,
   input  logic [TIME_BITS:0]             run_min,
   input  logic                           run_any,
   output etas_pkg::age_ctl_type          ctl,
   output logic [TIME_BITS:0]             cand
);

   localparam int WIDE_W = TIME_BITS + 1;
   localparam int SUM_W  = ((TIME_BITS > etas_pkg::GRACE_W) ? TIME_BITS
                                                              : etas_pkg::GRACE_W) + 1;

   logic [SUM_W-1:0] sum;
   logic             past_grace;
   logic             due;
   logic             saturate;
   logic             aged;

   always_comb begin
      sum        = SUM_W'(deadline) + SUM_W'(grace);
      past_grace = SUM_W'(now) > sum;
      due        = deadline <= now;
      saturate   = sum > SUM_W'({WIDE_W{1'b1}});
      aged       = flags.expired || due;

      if (!aged) begin
         cand = WIDE_W'(deadline);
      end else if (saturate) begin
         cand = '1;
      end else begin
         cand = sum[WIDE_W-1:0];
      end

      ctl = '0;
      if (flags.used) begin
         if (flags.expired && past_grace) begin
            ctl.emit     = 1'b1;
            ctl.kind     = etas_pkg::KIND_FREED;
            ctl.clr_used = 1'b1;
         end else begin
            // a slot marked in this pass is kept until a later pass
            if (!flags.expired && due) begin
               ctl.emit        = 1'b1;
               ctl.kind        = etas_pkg::KIND_EXPIRED;
               ctl.set_expired = 1'b1;
            end
            ctl.keep     = 1'b1;
            ctl.take_min = !run_any || (cand < run_min);
         end
      end
   end

endmodule

/* hdl/expiry_table_aging_sweep_core.sv */
// ----------------------------------------------------------------------------
// expiry_table_aging_sweep_core
// Slot table with expiry marking, grace-period freeing and deadline summary.
// ----------------------------------------------------------------------------
// A write or remove request is taken while the block is idle and gives no
// result. A sweep request steps through the table one slot per cycle while the
// result side does not stall an event, bound by the single read port of the
// deadline memory feeding one shared add and compare unit; no request is
// taken until the sweep ends. Each slot marked expired or freed gives one
// event, and the summary (last = 1) ends the sweep. Slot flags reset at once,
// so no clearing pass is needed; the grace register may be written at any
// time the block is idle.
// ----------------------------------------------------------------------------
module expiry_table_aging_sweep_core #(
   parameter int TABLE_DEPTH = 32,
   parameter int TIME_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   etas_req_if.sink     req_if,
   etas_rsp_if.source   rsp_if,
   etas_csr_if.sink     csr_if
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WIDE_W = TIME_BITS + 1;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SWEEP   = 2'd1;
   localparam logic [1:0] ST_SUMMARY = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             issue_cnt_ff, issue_cnt_in;
   logic                         ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]             ev_idx_ff, ev_idx_in;
   logic [TIME_BITS-1:0]         now_ff, now_in;
   logic [WIDE_W-1:0]            min_ff, min_in;
   logic                         any_ff, any_in;
   logic [etas_pkg::GRACE_W-1:0] grace_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_kind_ff;
   logic [4:0]                   rsp_slot_ff;
   logic [WIDE_W-1:0]            rsp_deadline_ff;
   logic                         rsp_dvalid_ff;
   logic                         rsp_last_ff;

   logic                         emit;
   logic [1:0]                   emit_kind;
   logic [4:0]                   emit_slot;
   logic [WIDE_W-1:0]            emit_deadline;
   logic                         emit_dvalid;
   logic                         emit_last;

   logic                         req_fire;
   logic                         slot_in_range;
   logic                         is_write;
   logic                         is_remove;
   logic                         out_blocked;
   logic                         advance;
   logic                         issue_done;
   logic [IDX_W-1:0]             issue_idx;

   logic                         rd_en;
   logic [TIME_BITS-1:0]         rd_data;
   logic                         upd_en;
   logic [IDX_W-1:0]             upd_idx;
   etas_pkg::slot_flags_type     upd_flags;
   etas_pkg::slot_flags_type     flags;
   etas_pkg::age_ctl_type        ctl;
   logic [WIDE_W-1:0]            cand;

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign csr_if.ready  = 1'b1;
   assign req_fire      = req_if.valid && req_if.ready;
   assign slot_in_range = 7'(req_if.slot) < 7'(TABLE_DEPTH);
   assign is_write      = req_if.mode == etas_pkg::MODE_WRITE;
   assign is_remove     = req_if.mode == etas_pkg::MODE_REMOVE;

   assign out_blocked = rsp_valid_ff && !rsp_if.ready;
   // hold the sweep while an event waits for a full output register
   assign advance     = !(ev_valid_ff && ctl.emit && out_blocked);
   assign issue_done  = issue_cnt_ff == CNT_W'(TABLE_DEPTH);
   assign issue_idx   = issue_cnt_ff[IDX_W-1:0];

   etas_slot_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (req_fire && is_write && slot_in_range),
      .wr_idx    (IDX_W'(req_if.slot)),
      .wr_data   (req_if.expiry_time),
      .rd_en     (rd_en),
      .rd_idx    (issue_idx),
      .rd_data   (rd_data),
      .upd_en    (upd_en),
      .upd_idx   (upd_idx),
      .upd_flags (upd_flags),
      .flag_idx  (ev_idx_ff),
      .flags     (flags)
   );

   etas_age_unit #(
      .TIME_BITS (TIME_BITS)
   ) u_age (
      .flags    (flags),
      .deadline (rd_data),
      .now      (now_ff),
      .grace    (grace_ff),
      .run_min  (min_ff),
      .run_any  (any_ff),
      .ctl      (ctl),
      .cand     (cand)
   );

   always_comb begin
      upd_en    = 1'b0;
      upd_idx   = ev_idx_ff;
      upd_flags = '0;
      if (req_fire && (is_write || is_remove) && slot_in_range) begin
         upd_en         = 1'b1;
         upd_idx        = IDX_W'(req_if.slot);
         upd_flags.used = is_write;
      end else if ((state_ff == ST_SWEEP) && ev_valid_ff && advance
                   && (ctl.clr_used || ctl.set_expired)) begin
         upd_en            = 1'b1;
         upd_flags.used    = !ctl.clr_used;
         upd_flags.expired = ctl.set_expired;
      end
   end

   always_comb begin
      state_in      = state_ff;
      issue_cnt_in  = issue_cnt_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      now_in        = now_ff;
      min_in        = min_ff;
      any_in        = any_ff;
      rd_en         = 1'b0;
      emit          = 1'b0;
      emit_kind     = ctl.kind;
      emit_slot     = 5'(ev_idx_ff);
      emit_deadline = '0;
      emit_dvalid   = 1'b0;
      emit_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.mode == etas_pkg::MODE_SWEEP)) begin
               state_in     = ST_SWEEP;
               issue_cnt_in = '0;
               ev_valid_in  = 1'b0;
               now_in       = req_if.now_time;
               min_in       = '1;
               any_in       = 1'b0;
            end
         end
         ST_SWEEP: begin
            if (advance) begin
               if (!issue_done) begin
                  rd_en        = 1'b1;
                  ev_valid_in  = 1'b1;
                  ev_idx_in    = issue_idx;
                  issue_cnt_in = issue_cnt_ff + 1'b1;
               end else begin
                  ev_valid_in = 1'b0;
                  state_in    = ST_SUMMARY;
               end
               if (ev_valid_ff) begin
                  emit = ctl.emit;
                  if (ctl.keep) begin
                     any_in = 1'b1;
                  end
                  if (ctl.take_min) begin
                     min_in = cand;
                  end
               end
            end
         end
         ST_SUMMARY: begin
            if (!out_blocked) begin
               emit          = 1'b1;
               emit_kind     = etas_pkg::KIND_SUMMARY;
               emit_slot     = '0;
               emit_deadline = any_ff ? min_ff : '0;
               emit_dvalid   = any_ff;
               emit_last     = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= '0;
         ev_valid_ff  <= 1'b0;
         any_ff       <= 1'b0;
         min_ff       <= '1;
         grace_ff     <= etas_pkg::GRACE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         ev_valid_ff  <= ev_valid_in;
         any_ff       <= any_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            grace_ff <= csr_if.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= ev_idx_in;
      now_ff    <= now_in;
      if (emit) begin
         rsp_kind_ff     <= emit_kind;
         rsp_slot_ff     <= emit_slot;
         rsp_deadline_ff <= emit_deadline;
         rsp_dvalid_ff   <= emit_dvalid;
         rsp_last_ff     <= emit_last;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.event_kind     = rsp_kind_ff;
   assign rsp_if.event_slot     = rsp_slot_ff;
   assign rsp_if.next_deadline  = rsp_deadline_ff;
   assign rsp_if.deadline_valid = rsp_dvalid_ff;
   assign rsp_if.last           = rsp_last_ff;

`ifndef SYNTHESIS
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_kind_ff == etas_pkg::KIND_SUMMARY)))
      else $error("last flag and summary kind disagree");

   a_no_deadline_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_dvalid_ff) |-> (rsp_deadline_ff == '0))
      else $error("deadline without valid flag");

   a_event_on_used: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && ev_valid_ff && ctl.emit) |-> flags.used)
      else $error("event raised for a free slot");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("sweep counter ran past the table");
`endif

endmodule

/* tb/etas_sweep_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// etas_sweep_checker
// Watches the request, result and grace channels of the aging sweep core,
// keeps its own copy of the slot table, works out the events and summary of
// every sweep and compares them in order with the results the core returns.
// ----------------------------------------------------------------------------
module etas_sweep_checker #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic clock,
   input  logic reset,
   etas_req_if  req_mon,
   etas_rsp_if  rsp_mon,
   etas_csr_if  csr_mon,
   output int   mismatch_count,
   output int   outstanding
);

   typedef struct {
      logic [1:0]  kind;
      logic [4:0]  slot;
      logic [32:0] deadline;
      logic        dl_valid;
      logic        last;
   } aging_event_type;

   aging_event_type             event_q[$];
   logic                        live[TABLE_DEPTH];
   logic                        aged[TABLE_DEPTH];
   logic [31:0]                 due[TABLE_DEPTH];
   logic [etas_pkg::GRACE_W-1:0] grace;

   function automatic aging_event_type make_event(input logic [1:0] kind,
                                                  input logic [4:0] slot,
                                                  input logic [32:0] deadline,
                                                  input logic dl_valid,
                                                  input logic last);
      aging_event_type ev;
      ev.kind     = kind;
      ev.slot     = slot;
      ev.deadline = deadline;
      ev.dl_valid = dl_valid;
      ev.last     = last;
      return ev;
   endfunction

   // Visit the slots in ascending order; a slot marked expired here is not
   // freed until a later sweep.
   task automatic age_table(input logic [31:0] now);
      logic [32:0] least;
      logic [32:0] cand;
      logic        any;
      any   = 1'b0;
      least = '1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!live[i]) continue;
         if (aged[i]) begin
            if ({1'b0, now} > {1'b0, due[i]} + {1'b0, grace}) begin
               live[i] = 1'b0;
               aged[i] = 1'b0;
               due[i]  = '0;
               event_q.push_back(make_event(etas_pkg::KIND_FREED, 5'(i), '0,
                                            1'b0, 1'b0));
               continue;
            end
         end else if (due[i] <= now) begin
            aged[i] = 1'b1;
            event_q.push_back(make_event(etas_pkg::KIND_EXPIRED, 5'(i), '0,
                                         1'b0, 1'b0));
         end
         cand = aged[i] ? {1'b0, due[i]} + {1'b0, grace} : {1'b0, due[i]};
         if (!any || cand < least) least = cand;
         any = 1'b1;
      end
      event_q.push_back(make_event(etas_pkg::KIND_SUMMARY, '0, any ? least : '0,
                                   any, 1'b1));
   endtask

   task automatic check_result();
      aging_event_type want;
      if (event_q.size() == 0) begin
         $error("unexpected result: event_kind %0d, event_slot %0d",
                rsp_mon.event_kind, rsp_mon.event_slot);
         mismatch_count++;
         return;
      end
      want = event_q.pop_front();
      if (rsp_mon.event_kind !== want.kind) begin
         $error("event_kind: expected %0d, got %0d", want.kind, rsp_mon.event_kind);
         mismatch_count++;
      end
      if (rsp_mon.event_slot !== want.slot) begin
         $error("event_slot: expected %0d, got %0d", want.slot, rsp_mon.event_slot);
         mismatch_count++;
      end
      if (rsp_mon.next_deadline !== want.deadline) begin
         $error("next_deadline: expected 0x%0h, got 0x%0h",
                want.deadline, rsp_mon.next_deadline);
         mismatch_count++;
      end
      if (rsp_mon.deadline_valid !== want.dl_valid) begin
         $error("deadline_valid: expected %0d, got %0d",
                want.dl_valid, rsp_mon.deadline_valid);
         mismatch_count++;
      end
      if (rsp_mon.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, rsp_mon.last);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            live[i] = 1'b0;
            aged[i] = 1'b0;
            due[i]  = '0;
         end
         grace = etas_pkg::GRACE_RESET;
         event_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) grace = csr_mon.wdata;
         // older results first, a request taken at this edge only adds later ones
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.mode)
               etas_pkg::MODE_WRITE: begin
                  live[req_mon.slot] = 1'b1;
                  aged[req_mon.slot] = 1'b0;
                  due[req_mon.slot]  = req_mon.expiry_time;
               end
               etas_pkg::MODE_REMOVE: begin
                  live[req_mon.slot] = 1'b0;
                  aged[req_mon.slot] = 1'b0;
                  due[req_mon.slot]  = '0;
               end
               etas_pkg::MODE_SWEEP: age_table(req_mon.now_time);
               default: ;
            endcase
         end
      end
      outstanding = event_q.size();
   end

endmodule

/* tb/expiry_table_aging_sweep_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expiry_table_aging_sweep_core_tb
// Drives writes, removes and sweeps into the aging sweep core: a directed run
// over the time and grace extremes, then random phases of mostly well-formed table
// traffic with advancing time under several grace settings, with random
// stalls on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module expiry_table_aging_sweep_core_tb;

   localparam int TABLE_DEPTH     = 32;
   localparam int TIME_BITS       = 32;
   localparam int CLK_PERIOD      = 8;
   localparam int RESET_CYCLES    = 11;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_REQUESTS  = 80;
   localparam int DRAIN_CYCLES    = TABLE_DEPTH + 8;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 4_000_000;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock;
   logic reset;

   etas_req_if #(.TIME_BITS(TIME_BITS)) req_if ();
   etas_rsp_if #(.TIME_BITS(TIME_BITS)) rsp_if ();
   etas_csr_if                          csr_if ();

   int          mismatch_count;
   int          outstanding;
   int          cycle_count;
   bit          req_idle_on;
   bit          rsp_idle_on;
   bit          rsp_hold_req;
   bit          rsp_hold_done;
   logic [31:0] tick_base;

   expiry_table_aging_sweep_core #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   etas_sweep_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) aging_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_mon        (csr_if),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("expiry_table_aging_sweep_core_tb: errors");
            $finish;
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      rsp_if.ready  = 1'b0;
      rsp_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req && !rsp_hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_done = 1'b1;
            rsp_if.ready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 99) < 25) begin
            rsp_if.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic [1:0] mode, input logic [4:0] slot,
                               input logic [31:0] expiry, input logic [31:0] now);
      int gap;
      req_if.valid       <= 1'b1;
      req_if.mode        <= mode;
      req_if.slot        <= slot;
      req_if.expiry_time <= expiry;
      req_if.now_time    <= now;
      do @(posedge clock); while (!req_if.ready);
      gap = (req_idle_on && $urandom_range(0, 99) < 35) ? gap_len() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // only while idle: every result back, then let any sweep tail run out
   task automatic write_grace(input logic [31:0] value);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.wdata <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [31:0] grace_for_phase(input int phase);
      case (phase)
         0: return $urandom_range(0, 30);
         1: return 32'hFFFF_FFFF;
         2: return '0;
         3: return $urandom;
         4: return etas_pkg::GRACE_RESET;
         default: return $urandom_range(1, 100);
      endcase
   endfunction

   // well-formed traffic around a moving time base, with some stray values
   task automatic random_request(output bit counted);
      int          r;
      logic [4:0]  slot;
      logic [31:0] expiry;
      logic [31:0] now;
      r       = $urandom_range(0, 99);
      slot    = 5'($urandom_range(0, 31));
      counted = 1'b1;
      if (r < 45) begin
         expiry = ($urandom_range(0, 99) < 85) ? tick_base + $urandom_range(0, 80)
                                               : $urandom;
         send_request(etas_pkg::MODE_WRITE, slot, expiry, $urandom);
      end else if (r < 60) begin
         send_request(etas_pkg::MODE_REMOVE, slot, $urandom, $urandom);
      end else if (r < 63) begin
         counted = 1'b0;
         send_request(MODE_UNUSED, slot, $urandom, $urandom);
      end else begin
         tick_base = tick_base + $urandom_range(0, 40);
         r = $urandom_range(0, 99);
         if (r < 88)      now = tick_base;
         else if (r < 94) now = tick_base - $urandom_range(1, 20);
         else             now = $urandom;
         send_request(etas_pkg::MODE_SWEEP, slot, $urandom, now);
      end
   endtask

   initial begin
      int sent;
      bit counted;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.mode        = etas_pkg::MODE_WRITE;
      req_if.slot        = '0;
      req_if.expiry_time = '0;
      req_if.now_time    = '0;
      csr_if.valid       = 1'b0;
      csr_if.wdata       = '0;
      req_idle_on        = 1'b1;
      rsp_idle_on        = 1'b1;
      rsp_hold_req       = 1'b0;
      tick_base          = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, time extremes, grace boundary, time going back
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, '0);
      send_request(etas_pkg::MODE_WRITE,  5'd0,  '0, '0);
      send_request(etas_pkg::MODE_WRITE,  5'd31, 32'hFFFF_FFFF, '0);
      send_request(etas_pkg::MODE_WRITE,  5'd5,  32'd100, 32'hFFFF_FFFF);
      send_request(MODE_UNUSED,           5'd7,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(etas_pkg::MODE_REMOVE, 5'd9,  '0, '0);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, '0);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, 32'd10);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, 32'd5);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, 32'd11);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, 32'd100);
      send_request(etas_pkg::MODE_SWEEP,  5'd31, '0, 32'hFFFF_FFFF);
      send_request(etas_pkg::MODE_REMOVE, 5'd31, '0, '0);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, 32'hFFFF_FFFF);
      send_request(etas_pkg::MODE_WRITE,  5'd21, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(etas_pkg::MODE_WRITE,  5'd10, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(etas_pkg::MODE_SWEEP,  5'd10, 32'h5555_5555, 32'h5555_5555);
      write_grace(32'hFFFF_FFFF);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, 32'hFFFF_FFFF);
      write_grace('0);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, 32'h5555_5556);
      send_request(etas_pkg::MODE_SWEEP,  5'd0,  '0, 32'hAAAA_AAAB);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_grace(grace_for_phase(phase));
         req_idle_on = (phase != 2);
         rsp_idle_on = (phase != 2) && (phase != 4);
         tick_base   = $urandom;
         sent        = 0;
         while (sent < PHASE_REQUESTS) begin
            // hold results back while requests keep coming
            if (phase == 3 && sent == 10) rsp_hold_req = 1'b1;
            random_request(counted);
            if (counted) sent++;
         end
      end

      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("expiry_table_aging_sweep_core_tb: clean");
      end else begin
         $display("expiry_table_aging_sweep_core_tb: errors");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/etas_pkg.sv
hdl/etas_req_if.sv
hdl/etas_rsp_if.sv
hdl/etas_csr_if.sv
hdl/etas_slot_table.sv
hdl/etas_age_unit.sv
hdl/expiry_table_aging_sweep_core.sv
tb/etas_sweep_checker.sv
tb/expiry_table_aging_sweep_core_tb.sv
